/* src/rlht_pkg.sv */
package rlht_pkg;

    localparam int COORD_WIDTH_DEF  = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ANG_W            = 26;
    localparam int FACE_W           = 16;
    localparam int TIME_W           = 16;
    localparam int SPEED_W          = 16;
    localparam int YAW_W            = 17;
    localparam logic [15:0] TURN_SPEED_RST = 16'd23040;
    localparam logic [16:0] DEG180_Q88     = 17'd46080;
    localparam logic [ANG_W-1:0] DEG90_Q816 = ANG_W'(90 * 65536);

    function automatic logic [ANG_W-1:0] atan_q816(input int i);
        logic [ANG_W-1:0] v;
        case (i)
            0: v = 26'd2949120;
            1: v = 26'd1740967;
            2: v = 26'd919879;
            3: v = 26'd466945;
            4: v = 26'd234379;
            5: v = 26'd117304;
            6: v = 26'd58666;
            7: v = 26'd29335;
            8: v = 26'd14668;
            9: v = 26'd7334;
            10: v = 26'd3667;
            11: v = 26'd1833;
            12: v = 26'd917;
            13: v = 26'd458;
            14: v = 26'd229;
            15: v = 26'd115;
            16: v = 26'd57;
            17: v = 26'd29;
            18: v = 26'd14;
            19: v = 26'd7;
            20: v = 26'd4;
            21: v = 26'd2;
            22: v = 26'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* src/rlht_if.sv */
interface rlht_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/rlht_front.sv */
// products of offset and facing, rate product, and no-turn classification
module rlht_front
    import rlht_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int PW = CW + 18,
    parameter int BW = 2 * (PW + 1) + ANG_W + 17 + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_turret_x,
    input  logic signed [CW-1:0] i_turret_z,
    input  logic signed [CW-1:0] i_target_x,
    input  logic signed [CW-1:0] i_target_z,
    input  logic signed [15:0]   i_facing_x,
    input  logic signed [15:0]   i_facing_z,
    input  logic [15:0]          i_delta_time,
    input  logic [15:0]          i_turn_speed,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [BW-1:0]        o_data
);
    // stage 1: products, stage 2: sums and cordic setup
    logic              r_v1, r_v2;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [31:0]       r_rp;
    logic signed [PW-1:0] n_cross, n_dot, n_ac;
    logic [16:0]       n_rate;
    logic              n_neg, n_swap;
    logic signed [PW:0] n_x, n_y;
    logic [BW-1:0]     r_d2;
    logic signed [CW:0] ox, oz;
    logic              adv;

    assign adv     = !r_v2 || i_ready;
    assign o_ready = adv;
    assign ox = (CW+1)'(i_turret_x) - (CW+1)'(i_target_x);
    assign oz = (CW+1)'(i_turret_z) - (CW+1)'(i_target_z);

    always_comb begin
        n_cross = r_p0 - r_p1;
        n_dot   = r_p2 + r_p3;
        n_ac    = n_cross[PW-1] ? -n_cross : n_cross;
        // target-to-turret cross is -cross: a positive cross turns positive
        n_neg   = n_cross < 0;
        n_swap  = n_dot[PW-1];
        if (n_swap) begin
            n_x = (PW+1)'(n_ac);
            n_y = -(PW+1)'(n_dot);
        end else begin
            n_x = (PW+1)'(n_dot);
            n_y = (PW+1)'(n_ac);
        end
        n_rate = (r_rp + 32'd32768) >> 16 > 32'(DEG180_Q88)
               ? DEG180_Q88 : 17'((r_rp + 32'd32768) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (adv) begin
            r_p0 <= PW'(ox * i_facing_z);
            r_p1 <= PW'(oz * i_facing_x);
            r_p2 <= PW'(ox * i_facing_x);
            r_p3 <= PW'(oz * i_facing_z);
            r_rp <= i_turn_speed * i_delta_time;
            r_d2 <= {n_x, n_y, n_swap ? DEG90_Q816 : ANG_W'(0), n_rate,
                     n_neg, n_cross != 0};
        end
    end

    assign o_valid = r_v2;
    assign o_data  = {r_d2[BW-1:1], r_d2[0]};
endmodule

/* src/rlht_queue.sv */
// small two-entry fifo between classifier and cordic pipe
module rlht_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

/* src/rlht_back.sv */
// unrolled cordic vectoring pipeline, one stage per iteration, then rounding and limit
module rlht_back
    import rlht_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF,
    parameter int PW    = 42,
    parameter int BW    = 2 * (PW + 1) + ANG_W + 17 + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [BW-1:0]    i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [YAW_W-1:0] o_yaw_delta,
    output logic             o_turned
);
    localparam int N  = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
    localparam int XW = PW + 2;

    logic                    r_v [N+1];
    logic signed [XW-1:0]    r_x [N+1];
    logic signed [XW-1:0]    r_y [N+1];
    logic signed [ANG_W-1:0] r_z [N+1];
    logic [16:0]             r_rate [N+1];
    logic                    r_neg [N+1];
    logic                    r_nz [N+1];
    logic                    r_ov;
    logic [YAW_W-1:0]        r_yaw;
    logic                    r_turn;
    logic                    adv;
    logic signed [ANG_W-1:0] rnd;
    logic [16:0]             ang, mag;

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;

    always_comb begin
        rnd = (r_z[N] + $signed(ANG_W'(128))) >>> 8;
        if (rnd < 0) ang = '0;
        else if (rnd > ANG_W'(DEG180_Q88)) ang = DEG180_Q88;
        else ang = 17'(rnd);
        mag = (r_rate[N] < ang) ? r_rate[N] : ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= N; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[N];
        end
        if (adv) begin
            r_x[0]    <= XW'($signed(i_data[BW-1 -: PW+1]));
            r_y[0]    <= XW'($signed(i_data[BW-PW-2 -: PW+1]));
            r_z[0]    <= $signed(i_data[ANG_W+18 -: ANG_W]);
            r_rate[0] <= i_data[18:2];
            r_neg[0]  <= i_data[1];
            r_nz[0]   <= i_data[0];
            for (int k = 0; k < N; k++) begin
                if (r_y[k] >= 0) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q816(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q816(k);
                end
                r_rate[k+1] <= r_rate[k];
                r_neg[k+1]  <= r_neg[k];
                r_nz[k+1]   <= r_nz[k];
            end
            r_turn <= r_nz[N];
            if (!r_nz[N]) r_yaw <= '0;
            else r_yaw <= r_neg[N] ? -mag : mag;
        end
    end

    assign o_valid     = r_ov;
    assign o_yaw_delta = r_yaw;
    assign o_turned    = r_turn;
endmodule

/* src/rate_limited_heading_tracker_core.sv */
// path: 2 front stages, then the two-entry queue, then the back cordic stages and rounding
// throughput: one request per cycle while the output is not stalled, set by the unrolled cordic pipeline
// reset: synchronous active low, clears valids; turn_speed returns to 90 deg/s
module rate_limited_heading_tracker_core
    import rlht_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rlht_if.sink  in_ch,
    rlht_if.sink  cfg_ch,
    rlht_if.source out_ch
);
    localparam int PW = COORD_WIDTH + 18;
    localparam int BW = 2 * (PW + 1) + ANG_W + 17 + 2;
    localparam int CW = COORD_WIDTH;

    logic [15:0]   r_turn_speed;
    logic          f_v, f_r, q_v, q_r;
    logic [BW-1:0] f_d, q_d;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_turn_speed <= TURN_SPEED_RST;
        else if (cfg_ch.valid) r_turn_speed <= cfg_ch.data;
    end

    rlht_front #(.CW(CW), .PW(PW), .BW(BW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_turret_x(in_ch.data[CW-1:0]),
        .i_turret_z(in_ch.data[2*CW-1:CW]),
        .i_target_x(in_ch.data[3*CW-1:2*CW]),
        .i_target_z(in_ch.data[4*CW-1:3*CW]),
        .i_facing_x(in_ch.data[4*CW+15:4*CW]),
        .i_facing_z(in_ch.data[4*CW+31:4*CW+16]),
        .i_delta_time(in_ch.data[4*CW+47:4*CW+32]),
        .i_turn_speed(r_turn_speed),
        .o_valid(f_v), .i_ready(f_r), .o_data(f_d)
    );

    rlht_queue #(.W(BW)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_v), .o_ready(f_r), .i_data(f_d),
        .o_valid(q_v), .i_ready(q_r), .o_data(q_d)
    );

    rlht_back #(.STEPS(CORDIC_STEPS), .PW(PW), .BW(BW)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_v), .o_ready(q_r), .i_data(q_d),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_yaw_delta(out_ch.data[YAW_W-1:0]), .o_turned(out_ch.data[YAW_W])
    );
endmodule

/* src/rlht_checker.sv */
module rlht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [17:0] out_data,
    input logic        cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");
    a_noturn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data[17] |-> out_data[16:0] == 17'd0)
        else $error("yaw without turn");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n) cfg_ready)
        else $error("config not ready");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("valid after reset");
endmodule

bind rate_limited_heading_tracker_core rlht_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data), .cfg_ready(cfg_ch.ready)
);
